>>> hw/rtl/u8dec_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// u8dec_pkg - shared types and constants for the UTF-8 stream decoder
// Beat structs for both channels, code point limits and lead-byte helpers.
// ============================================================================
package u8dec_pkg;

    // Input beat: one raw byte plus end-of-stream flag
    typedef struct packed {
        logic [7:0] byte_in;
        logic       stream_end;
    } t_in_beat;

    // Output beat: one decoded scalar
    typedef struct packed {
        logic [20:0] scalar;
        logic [2:0]  byte_count;
        logic [1:0]  utf16_units;
        logic        run_last;
    } t_out_beat;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00fffd;
    localparam logic [20:0] MAX_SCALAR       = 21'h10ffff;
    localparam logic [20:0] SURROGATE_LO     = 21'h00d800;
    localparam logic [20:0] SURROGATE_HI     = 21'h00dfff;
    localparam logic [20:0] MIN_FOUR_BYTE    = 21'h010000;
    localparam logic [20:0] MIN_THREE_BYTE   = 21'h000800;
    localparam logic [20:0] BMP_MAX          = 21'h00ffff;
    localparam logic [7:0]  LEAD_TWO_LO      = 8'hc2;
    localparam logic [7:0]  LEAD_TWO_HI      = 8'hdf;
    localparam logic [7:0]  LEAD_THREE_LO    = 8'he0;
    localparam logic [7:0]  LEAD_THREE_HI    = 8'hef;
    localparam logic [7:0]  LEAD_FOUR_LO     = 8'hf0;
    localparam logic [7:0]  LEAD_FOUR_HI     = 8'hf4;
    localparam logic [7:0]  ASCII_LIMIT      = 8'h80;
    localparam logic [7:0]  CONT_MASK        = 8'hc0;
    localparam logic [7:0]  CONT_TAG         = 8'h80;
    localparam logic [7:0]  PAYLOAD_MASK     = 8'h3f;

    // Sequence length opened by a lead byte, 0 when not a valid lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= LEAD_TWO_LO && b <= LEAD_TWO_HI) begin
            len = 3'd2;
        end else if (b >= LEAD_THREE_LO && b <= LEAD_THREE_HI) begin
            len = 3'd3;
        end else if (b >= LEAD_FOUR_LO && b <= LEAD_FOUR_HI) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Payload bits kept from a lead byte of the given length
    function automatic logic [20:0] lead_payload(input logic [7:0] b, input logic [2:0] len);
        logic [20:0] v;
        unique case (len)
            3'd2:    v = {16'd0, b[4:0]};
            3'd3:    v = {17'd0, b[3:0]};
            3'd4:    v = {18'd0, b[2:0]};
            default: v = 21'd0;
        endcase
        return v;
    endfunction

    // Rejects overlong 3/4-byte forms, surrogates and values past the top
    function automatic logic value_ok(input logic [2:0] len, input logic [20:0] v);
        logic ok;
        ok = 1'b1;
        if (len == 3'd3 && v < MIN_THREE_BYTE) ok = 1'b0;
        if (len == 3'd4 && v < MIN_FOUR_BYTE)  ok = 1'b0;
        if (v >= SURROGATE_LO && v <= SURROGATE_HI) ok = 1'b0;
        if (v > MAX_SCALAR) ok = 1'b0;
        return ok;
    endfunction

endpackage

>>> hw/rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_stream_decoder - streaming UTF-8 decoder with per-byte replacement
// Takes one byte per beat and emits Unicode scalars with byte and UTF-16
// unit counts; rejected bytes each become U+FFFD.
// ============================================================================
//
//  channel | direction | beat type           | handshake
//  --------+-----------+---------------------+---------------------------
//  in      | input     | u8dec_pkg::t_in_beat  | i_in_valid / o_in_ready
//  out     | output    | u8dec_pkg::t_out_beat | o_out_valid / i_out_ready
//
//  Each accepted byte is decoded in the cycle it arrives and its results
//  land in a result group register: up to four U+FFFD replacements followed
//  by at most one tail scalar, at most four results per byte in all. The
//  group drains one beat per cycle while i_out_ready is high. The next
//  byte is taken in the same cycle the group's last beat leaves. Reset
//  (i_rst_n low, synchronous) drops any pending sequence and any
//  undelivered results. A stalled output holds the current beat and
//  back-pressures the input once the group is down to it.
//
module utf8_stream_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  u8dec_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output u8dec_pkg::t_out_beat o_out_data
);

    // Pending sequence state
    logic [2:0]  r_seq_len, n_seq_len;     // 0 = no sequence open
    logic [1:0]  r_held, n_held;           // bytes of the sequence taken so far
    logic [20:0] r_partial, n_partial;     // payload bits gathered so far

    // Result group: replacements first, then the optional tail scalar
    logic [2:0]  r_rep_cnt, n_rep_cnt;
    logic        r_has_tail, n_has_tail;
    logic [20:0] r_tail_scalar, n_tail_scalar;
    logic [2:0]  r_tail_count, n_tail_count;

    logic       in_fire, out_fire;
    logic [3:0] items_left;
    logic [7:0] b;
    logic       last;
    logic       is_cont;
    logic [20:0] cont_value;
    logic [2:0]  cont_count;
    logic [2:0]  lead_len;

    assign b          = i_in_data.byte_in;
    assign last       = i_in_data.stream_end;
    assign is_cont    = (b & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG;
    assign cont_value = {r_partial[14:0], b[5:0] & u8dec_pkg::PAYLOAD_MASK[5:0]};
    assign cont_count = {1'b0, r_held} + 3'd1;
    assign lead_len   = u8dec_pkg::lead_length(b);

    assign items_left  = {1'b0, r_rep_cnt} + {3'd0, r_has_tail};
    assign o_out_valid = items_left != 4'd0;
    assign out_fire    = o_out_valid && i_out_ready;
    // Take a new byte once the group empties this cycle
    assign o_in_ready  = (items_left == 4'd0) || (items_left == 4'd1 && i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;

    // Output beat: replacements drain first, the tail closes the run
    always_comb begin
        if (r_rep_cnt != 3'd0) begin
            o_out_data.scalar      = u8dec_pkg::REPLACEMENT_CHAR;
            o_out_data.byte_count  = 3'd1;
            o_out_data.utf16_units = 2'd1;
            o_out_data.run_last    = (r_rep_cnt == 3'd1) && !r_has_tail;
        end else begin
            o_out_data.scalar      = r_tail_scalar;
            o_out_data.byte_count  = r_tail_count;
            o_out_data.utf16_units = (r_tail_scalar > u8dec_pkg::BMP_MAX) ? 2'd2 : 2'd1;
            o_out_data.run_last    = 1'b1;
        end
    end

    // Decode one byte against the pending sequence
    always_comb begin
        n_seq_len     = r_seq_len;
        n_held        = r_held;
        n_partial     = r_partial;
        n_rep_cnt     = r_rep_cnt;
        n_has_tail    = r_has_tail;
        n_tail_scalar = r_tail_scalar;
        n_tail_count  = r_tail_count;

        // Drain side
        if (out_fire) begin
            if (r_rep_cnt != 3'd0) begin
                n_rep_cnt = r_rep_cnt - 3'd1;
            end else begin
                n_has_tail = 1'b0;
            end
        end

        // Load side: the group is empty (or emptying) whenever this fires
        if (in_fire) begin
            n_rep_cnt  = 3'd0;
            n_has_tail = 1'b0;
            if (r_seq_len != 3'd0 && is_cont) begin
                if (cont_count >= r_seq_len) begin
                    // Sequence complete: check range, then clear
                    if (u8dec_pkg::value_ok(r_seq_len, cont_value)) begin
                        n_has_tail    = 1'b1;
                        n_tail_scalar = cont_value;
                        n_tail_count  = r_seq_len;
                    end else begin
                        n_rep_cnt = r_seq_len;
                    end
                    n_seq_len = 3'd0;
                    n_held    = 2'd0;
                    n_partial = 21'd0;
                end else if (last) begin
                    // Stream cut short mid-sequence
                    n_rep_cnt = cont_count;
                    n_seq_len = 3'd0;
                    n_held    = 2'd0;
                    n_partial = 21'd0;
                end else begin
                    n_held    = cont_count[1:0];
                    n_partial = cont_value;
                end
            end else begin
                // Broken sequence: flush held bytes, then decode afresh
                n_rep_cnt = (r_seq_len != 3'd0) ? {1'b0, r_held} : 3'd0;
                n_seq_len = 3'd0;
                n_held    = 2'd0;
                n_partial = 21'd0;
                if (b < u8dec_pkg::ASCII_LIMIT) begin
                    n_has_tail    = 1'b1;
                    n_tail_scalar = {13'd0, b};
                    n_tail_count  = 3'd1;
                end else if (lead_len == 3'd0 || last) begin
                    n_has_tail    = 1'b1;
                    n_tail_scalar = u8dec_pkg::REPLACEMENT_CHAR;
                    n_tail_count  = 3'd1;
                end else begin
                    n_seq_len = lead_len;
                    n_held    = 2'd1;
                    n_partial = u8dec_pkg::lead_payload(b, lead_len);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len  <= 3'd0;
            r_held     <= 2'd0;
            r_partial  <= 21'd0;
            r_rep_cnt  <= 3'd0;
            r_has_tail <= 1'b0;
        end else begin
            r_seq_len  <= n_seq_len;
            r_held     <= n_held;
            r_partial  <= n_partial;
            r_rep_cnt  <= n_rep_cnt;
            r_has_tail <= n_has_tail;
        end
    end

    // Tail payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_tail_scalar <= n_tail_scalar;
        r_tail_count  <= n_tail_count;
    end

endmodule

>>> bench/utf8_stream_decoder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_stream_decoder_test - self-checking bench for the UTF-8 stream decoder
// Feeds a directed table of byte sequences, then randomized streams built
// mostly from well-formed sequences with random content, mixed with noise,
// broken and truncated sequences. Every result beat is compared with the
// oldest expected scalar from a cycle-free decoder model kept in the bench.
// Both channels idle and stall at random, with calm stretches in between.
// ============================================================================
module utf8_stream_decoder_test;

    localparam int CLK_PERIOD  = 8;
    localparam int RESET_CYC   = 11;
    localparam int QUIET_LIMIT = 1000;  // cycles with no beat on either side
    localparam int DRAIN_CYC   = 16;    // settle time after the last result
    localparam int RANDOM_GOAL = 75;    // random bytes after the directed part
    localparam int REPORT_MAX  = 10;

    // One stimulus row. Where known is set, the row's results are typed in:
    // n_res results, all U+FFFD of width 1 except the last one, which carries
    // last_scalar / last_count. Other rows rely on the decoder model.
    typedef struct packed {
        logic [7:0]  octet;
        logic        fin;
        logic        known;
        logic [2:0]  n_res;
        logic [20:0] last_scalar;
        logic [2:0]  last_count;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_out_ready = 1'b0;
    u8dec_pkg::t_in_beat  i_in_data   = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    u8dec_pkg::t_out_beat o_out_data;

    utf8_stream_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Directed table: extremes, every error path, max results per byte
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [27] = '{
        // ASCII extremes, the second one flagged as end of stream
        '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 3'd1},
        '{8'h7f, 1'b1, 1'b1, 3'd1, 21'h00007f, 3'd1},
        // stray continuation, invalid leads at both ends of the range
        '{8'h80, 1'b0, 1'b1, 3'd1, 21'h00fffd, 3'd1},
        '{8'hc1, 1'b0, 1'b1, 3'd1, 21'h00fffd, 3'd1},
        '{8'hf5, 1'b0, 1'b1, 3'd1, 21'h00fffd, 3'd1},
        '{8'hff, 1'b0, 1'b1, 3'd1, 21'h00fffd, 3'd1},
        // smallest 2-byte scalar
        '{8'hc2, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd1, 21'h000080, 3'd2},
        // overlong 3-byte form: all three bytes replaced
        '{8'he0, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd3, 21'h00fffd, 3'd1},
        // surrogate D800
        '{8'hed, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'ha0, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd3, 21'h00fffd, 3'd1},
        // top scalar 10FFFF, two UTF-16 units
        '{8'hf4, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h8f, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'hbf, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'hbf, 1'b0, 1'b1, 3'd1, 21'h10ffff, 3'd4},
        // 110000 is past the top: four replacements from one byte
        '{8'hf4, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h90, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd0, 21'h000000, 3'd0},
        '{8'h80, 1'b0, 1'b1, 3'd4, 21'h00fffd, 3'd1},
        // bad continuation, breaking byte decoded afresh (model-checked)
        '{8'he2, 1'b0, 1'b0, 3'd0, 21'h000000, 3'd0},
        '{8'h41, 1'b0, 1'b0, 3'd0, 21'h000000, 3'd0},
        '{8'hf0, 1'b0, 1'b0, 3'd0, 21'h000000, 3'd0},
        '{8'hc2, 1'b1, 1'b0, 3'd0, 21'h000000, 3'd0},
        // valid lead flagged as end of stream
        '{8'he2, 1'b1, 1'b1, 3'd1, 21'h00fffd, 3'd1}
    };

    t_stim_row            stim_rows[$];        // everything the driver will send
    t_stim_row            beats_in_flight[$];  // rows presented, popped on acceptance
    u8dec_pkg::t_out_beat step_scalars[$];     // results of the byte just decoded
    u8dec_pkg::t_out_beat pending_scalars[$];  // expected results, oldest first

    // decoder model state
    logic [2:0]  seq_len  = 3'd0;
    logic [1:0]  seq_held = 2'd0;
    logic [20:0] seq_acc  = 21'd0;

    int unsigned          mismatches   = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          stall_left   = 0;
    bit                   in_smooth    = 1'b0;
    bit                   out_smooth   = 1'b0;
    t_stim_row            took_row;
    u8dec_pkg::t_out_beat want;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void add_scalar(logic [20:0] v, logic [2:0] cnt);
        u8dec_pkg::t_out_beat r;
        r.scalar      = v;
        r.byte_count  = cnt;
        r.utf16_units = (v > u8dec_pkg::BMP_MAX) ? 2'd2 : 2'd1;
        r.run_last    = 1'b0;
        step_scalars.push_back(r);
    endfunction

    // one U+FFFD per rejected byte, never more than four per input byte
    function automatic void add_replacements(int unsigned how_many);
        for (int unsigned i = 0; i < how_many && step_scalars.size() < 4; i++)
            add_scalar(u8dec_pkg::REPLACEMENT_CHAR, 3'd1);
    endfunction

    function automatic void mark_run_last();
        u8dec_pkg::t_out_beat r;
        if (step_scalars.size() != 0) begin
            r = step_scalars[step_scalars.size() - 1];
            r.run_last = 1'b1;
            step_scalars[step_scalars.size() - 1] = r;
        end
    endfunction

    function automatic logic [2:0] lead_span(logic [7:0] b);
        if (b >= u8dec_pkg::LEAD_TWO_LO && b <= u8dec_pkg::LEAD_TWO_HI) return 3'd2;
        if (b >= u8dec_pkg::LEAD_THREE_LO && b <= u8dec_pkg::LEAD_THREE_HI) return 3'd3;
        if (b >= u8dec_pkg::LEAD_FOUR_LO && b <= u8dec_pkg::LEAD_FOUR_HI) return 3'd4;
        return 3'd0;
    endfunction

    function automatic bit scalar_legal(logic [2:0] len, logic [20:0] v);
        if (len == 3'd3 && v < u8dec_pkg::MIN_THREE_BYTE) return 1'b0;
        if (len == 3'd4 && v < u8dec_pkg::MIN_FOUR_BYTE) return 1'b0;
        if (v >= u8dec_pkg::SURROGATE_LO && v <= u8dec_pkg::SURROGATE_HI) return 1'b0;
        return v <= u8dec_pkg::MAX_SCALAR;
    endfunction

    function automatic void clear_sequence();
        seq_len  = 3'd0;
        seq_held = 2'd0;
        seq_acc  = 21'd0;
    endfunction

    // Decodes one byte into step_scalars and advances the model state.
    function automatic void predict_scalars(logic [7:0] b, logic fin);
        logic [20:0] v;
        logic [2:0]  held_next;
        logic [2:0]  fresh_len;
        bit          settled;
        step_scalars.delete();
        settled = 1'b0;
        if (seq_len != 3'd0) begin
            if ((b & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG) begin
                v         = {seq_acc[14:0], b[5:0]};
                held_next = {1'b0, seq_held} + 3'd1;
                if (held_next >= seq_len) begin
                    // last byte in: range checks happen only now
                    if (scalar_legal(seq_len, v))
                        add_scalar(v, seq_len);
                    else
                        add_replacements(seq_len);
                    clear_sequence();
                end else if (fin) begin
                    add_replacements(held_next);
                    clear_sequence();
                end else begin
                    seq_held = held_next[1:0];
                    seq_acc  = v;
                end
                settled = 1'b1;
            end else begin
                // broken sequence: flush held bytes, then decode b afresh
                add_replacements(seq_held);
                clear_sequence();
            end
        end
        if (!settled) begin
            if (b < u8dec_pkg::ASCII_LIMIT) begin
                add_scalar({13'd0, b}, 3'd1);
            end else begin
                fresh_len = lead_span(b);
                if (fresh_len == 3'd0 || fin) begin
                    add_scalar(u8dec_pkg::REPLACEMENT_CHAR, 3'd1);
                end else begin
                    seq_len  = fresh_len;
                    seq_held = 2'd1;
                    seq_acc  = {13'd0, b & (8'h7f >> fresh_len)};
                end
            end
        end
        mark_run_last();
    endfunction

    // Replaces the model's results with the ones typed into the table.
    function automatic void load_typed(t_stim_row row);
        step_scalars.delete();
        for (int i = 1; i < row.n_res; i++)
            add_scalar(u8dec_pkg::REPLACEMENT_CHAR, 3'd1);
        if (row.n_res != 3'd0)
            add_scalar(row.last_scalar, row.last_count);
        mark_run_last();
    endfunction

    // ------------------------------------------------------------------------
    // Random stream builder
    // ------------------------------------------------------------------------
    function automatic void add_beat(logic [7:0] b, logic fin);
        stim_rows.push_back('{b, fin, 1'b0, 3'd0, 21'd0, 3'd0});
    endfunction

    // leans on the leads whose second byte is range limited
    function automatic logic [7:0] pick_lead(int unsigned len);
        if (len == 2)
            return 8'($urandom_range(u8dec_pkg::LEAD_TWO_LO, u8dec_pkg::LEAD_TWO_HI));
        if (len == 3) begin
            case ($urandom_range(0, 5))
                0:       return u8dec_pkg::LEAD_THREE_LO;
                1:       return 8'hed;
                2:       return u8dec_pkg::LEAD_THREE_HI;
                default: return 8'($urandom_range(u8dec_pkg::LEAD_THREE_LO,
                                                  u8dec_pkg::LEAD_THREE_HI));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return u8dec_pkg::LEAD_FOUR_LO;
            1:       return u8dec_pkg::LEAD_FOUR_HI;
            default: return 8'($urandom_range(u8dec_pkg::LEAD_FOUR_LO,
                                              u8dec_pkg::LEAD_FOUR_HI));
        endcase
    endfunction

    // continuation bytes, often on the overlong / surrogate / top boundaries
    function automatic logic [7:0] pick_cont();
        case ($urandom_range(0, 11))
            0:       return 8'h80;
            1:       return 8'h8f;
            2:       return 8'h90;
            3:       return 8'h9f;
            4:       return 8'ha0;
            5:       return 8'hbf;
            default: return 8'($urandom_range(8'h80, 8'hbf));
        endcase
    endfunction

    function automatic void add_random_run();
        int unsigned kind;
        int unsigned len;
        int unsigned held;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(2, 4);
        if (kind < 3) begin
            add_beat(8'($urandom_range(0, 8'h7f)), $urandom_range(0, 7) == 0);
        end else if (kind < 7) begin
            // well-formed shape, random content
            add_beat(pick_lead(len), 1'b0);
            for (int unsigned i = 1; i < len; i++)
                add_beat(pick_cont(), i == len - 1 && $urandom_range(0, 5) == 0);
        end else if (kind == 7) begin
            add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            // sequence broken by any byte, or cut short by the end flag
            held = $urandom_range(0, len - 2);
            add_beat(pick_lead(len), kind == 9 && held == 0);
            for (int unsigned i = 0; i < held; i++)
                add_beat(pick_cont(), kind == 9 && i == held - 1);
            if (kind == 8)
                add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_span();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 6);
        return $urandom_range(12, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Result side back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0 && !out_smooth && $urandom_range(0, 3) == 0)
            stall_left = idle_span();
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on each accepted byte, check each result beat.
    // Prediction comes first so a same-edge result would still find its entry.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                took_row = beats_in_flight.pop_front();
                predict_scalars(took_row.octet, took_row.fin);
                if (took_row.known)
                    load_typed(took_row);
                foreach (step_scalars[k])
                    pending_scalars.push_back(step_scalars[k]);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_scalars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected beat %h/%0d/%0d/%0d",
                                 $realtime, o_out_data.scalar, o_out_data.byte_count,
                                 o_out_data.utf16_units, o_out_data.run_last);
                end else begin
                    want = pending_scalars.pop_front();
                    if (o_out_data.scalar !== want.scalar
                            || o_out_data.byte_count !== want.byte_count
                            || o_out_data.utf16_units !== want.utf16_units
                            || o_out_data.run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: got %h/%0d/%0d/%0d expected %h/%0d/%0d/%0d",
                                     $realtime, o_out_data.scalar,
                                     o_out_data.byte_count,
                                     o_out_data.utf16_units, o_out_data.run_last,
                                     want.scalar, want.byte_count,
                                     want.utf16_units, want.run_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without a beat on either channel means a hang
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("utf8_stream_decoder test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------------
    initial begin : drive_bytes
        int unsigned gap;
        foreach (directed_rows[k])
            stim_rows.push_back(directed_rows[k]);
        while (stim_rows.size() < $size(directed_rows) + RANDOM_GOAL)
            add_random_run();

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int idx = 0; idx < stim_rows.size(); idx++) begin
            // new pacing every 20 bytes, some stretches run flat out
            if (idx % 20 == 0) begin
                in_smooth  = $urandom_range(0, 3) == 0;
                out_smooth = $urandom_range(0, 3) == 0;
            end
            gap = (in_smooth || $urandom_range(0, 2) != 0) ? 0 : idle_span();
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            beats_in_flight.push_back(stim_rows[idx]);
            i_in_valid           <= 1'b1;
            i_in_data.byte_in    <= stim_rows[idx].octet;
            i_in_data.stream_end <= stim_rows[idx].fin;
            do @(posedge i_clk); while (!o_in_ready);
        end
        i_in_valid <= 1'b0;

        // watchdog covers a result that never shows up
        while (pending_scalars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatches == 0)
            $display("utf8_stream_decoder test passed");
        else
            $display("utf8_stream_decoder test failed");
        $finish;
    end

endmodule
